### sv/urf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_pkg: shared types and constants of the UART register file
// Item layouts, operation and offset codes, and the bit assignments of the
// line control, interrupt enable and FIFO control registers.
// ----------------------------------------------------------------------------
package urf_pkg;

    // Operation codes
    localparam logic [1:0] OP_BUS_READ   = 2'd0;
    localparam logic [1:0] OP_BUS_WRITE  = 2'd1;
    localparam logic [1:0] OP_RX_BYTE    = 2'd2;
    localparam logic [1:0] OP_SHIFT_DONE = 2'd3;

    // Register offsets
    localparam logic [2:0] OFF_DATA    = 3'd0;
    localparam logic [2:0] OFF_IER     = 3'd1;
    localparam logic [2:0] OFF_ISR_FCR = 3'd2;
    localparam logic [2:0] OFF_LCR     = 3'd3;
    localparam logic [2:0] OFF_MCR     = 3'd4;
    localparam logic [2:0] OFF_LSR     = 3'd5;
    localparam logic [2:0] OFF_MSR     = 3'd6;
    localparam logic [2:0] OFF_SCRATCH = 3'd7;

    // Bit positions
    localparam int unsigned LCR_DLAB   = 7;
    localparam int unsigned IER_RX     = 0;
    localparam int unsigned IER_TX     = 1;
    localparam int unsigned IER_LS     = 2;
    localparam int unsigned FCR_ENABLE = 0;
    localparam int unsigned FCR_CLR_RX = 1;
    localparam int unsigned FCR_CLR_TX = 2;

    // Interrupt identification codes
    localparam logic [7:0] ISR_NONE    = 8'h01;
    localparam logic [7:0] ISR_LINE    = 8'h06;
    localparam logic [7:0] ISR_RXDATA  = 8'h04;
    localparam logic [7:0] ISR_THRE    = 8'h02;
    localparam logic [7:0] ISR_FIFO_ON = 8'hC0;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] line_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_pending;
    } out_item_t;

    // Per-item control carried alongside the RAM read
    typedef struct packed {
        logic [7:0] rd_value;
        logic       rd_from_rx;
        logic       tx_valid;
        logic       tx_fwd;
        logic [7:0] tx_fwd_data;
        logic       irq;
    } urf_meta_t;

    // Priority encoder of the interrupt identification register
    function automatic logic [7:0] isr_code(input logic [3:0] ier,
                                            input logic       overrun,
                                            input logic       rx_nonempty,
                                            input logic       thre_pend);
        logic [7:0] code;
        code = ISR_NONE;
        if (ier[IER_LS] && overrun) begin
            code = ISR_LINE;
        end else if (ier[IER_RX] && rx_nonempty) begin
            code = ISR_RXDATA;
        end else if (ier[IER_TX] && thre_pend) begin
            code = ISR_THRE;
        end
        return code;
    endfunction

endpackage

### sv/uart_register_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_file: 16550-style UART register file
// Bus accesses and line events in, one result item per item out.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one item per handshake: a bus read or write at offsets 0-7
//   (LCR bit 7 selects the divisor latch at offsets 0 and 1), a byte
//   received from the line, or the transmitter finishing a byte.
//   m_* returns exactly one item for each input item, in order: the read
//   data, the byte handed to the transmit shifter (tx_valid) and the
//   interrupt line as it stands after the item.
//   An accepted item passes the registered read of the receive or transmit
//   FIFO RAM, then the output register, before m_valid. Throughput is one
//   item per cycle while the output is not stalled; registers and FIFO
//   pointers are updated in the accept cycle, so back-to-back items see
//   each other's effects with no bubble.
//   When m_ready is low the output register holds its item, one more item
//   waits in the RAM read stage, and s_ready drops only once both are full.
//   Reset (aresetn low, synchronous) clears all UART registers, pointers and
//   flags; FIFO RAM contents are left as they are and need no clearing.
// ----------------------------------------------------------------------------
module uart_register_file #(
    parameter int RX_FIFO_DEPTH = 16,
    parameter int TX_FIFO_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  urf_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output urf_pkg::out_item_t  m_item
);

    localparam int RX_AW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int TX_AW = (TX_FIFO_DEPTH > 1) ? $clog2(TX_FIFO_DEPTH) : 1;

    logic               fire;
    logic               advance;
    logic               rx_we, rx_re, tx_we, tx_re;
    logic [RX_AW-1:0]   rx_waddr, rx_raddr;
    logic [TX_AW-1:0]   tx_waddr, tx_raddr;
    logic [7:0]         rx_wdata, tx_wdata, rx_rdata, tx_rdata;
    urf_pkg::urf_meta_t meta;

    logic               p1_valid_reg, p1_valid_next;
    urf_pkg::urf_meta_t p1_meta_reg;
    logic               out_valid_reg, out_valid_next;
    urf_pkg::out_item_t out_item_reg, out_item_next;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || advance;
    assign fire    = s_valid && s_ready;

    urf_ctrl #(
        .RX_FIFO_DEPTH (RX_FIFO_DEPTH),
        .TX_FIFO_DEPTH (TX_FIFO_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (s_item),
        .rx_we    (rx_we),
        .rx_waddr (rx_waddr),
        .rx_wdata (rx_wdata),
        .rx_re    (rx_re),
        .rx_raddr (rx_raddr),
        .tx_we    (tx_we),
        .tx_waddr (tx_waddr),
        .tx_wdata (tx_wdata),
        .tx_re    (tx_re),
        .tx_raddr (tx_raddr),
        .meta     (meta)
    );

    urf_ram #(
        .WIDTH (8),
        .DEPTH (RX_FIFO_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    urf_ram #(
        .WIDTH (8),
        .DEPTH (TX_FIFO_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // RAM read stage: holds item control while the read completes
    assign p1_valid_next = fire || (p1_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            p1_meta_reg <= meta;
        end
    end

    // Result assembly: merge RAM data with the stage control
    always_comb begin
        out_item_next.read_data   = p1_meta_reg.rd_from_rx ? rx_rdata
                                                           : p1_meta_reg.rd_value;
        out_item_next.tx_valid    = p1_meta_reg.tx_valid;
        out_item_next.tx_byte     = !p1_meta_reg.tx_valid ? 8'h00 :
                                    p1_meta_reg.tx_fwd    ? p1_meta_reg.tx_fwd_data
                                                          : tx_rdata;
        out_item_next.irq_pending = p1_meta_reg.irq;
    end

    assign out_valid_next = advance ? p1_valid_reg : out_valid_reg;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Back-pressure reaches the input only when both stages are full
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without both stages full and stalled");

    // An accepted item always occupies the RAM read stage next cycle
    a_fire_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> p1_valid_reg)
        else $error("accepted item lost before RAM read stage");

    // No transmit byte shown unless one was handed to the shifter
    a_tx_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.tx_valid) |-> (m_item.tx_byte == 8'h00))
        else $error("tx_byte nonzero without tx_valid");

    // A stage stuck behind a stalled output keeps its RAM data still
    a_ram_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !advance) |-> (!rx_re && !tx_re))
        else $error("FIFO RAM read issued while read stage is blocked");

endmodule

### sv/urf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module urf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/urf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_ctrl: register bank and FIFO pointer control
// Decodes each accepted item, updates the UART registers and FIFO pointers,
// issues the FIFO RAM reads and writes, and passes per-item control onward.
// ----------------------------------------------------------------------------
module urf_ctrl #(
    parameter int RX_FIFO_DEPTH = 16,
    parameter int TX_FIFO_DEPTH = 16,
    localparam int RX_AW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1,
    localparam int TX_AW = (TX_FIFO_DEPTH > 1) ? $clog2(TX_FIFO_DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  urf_pkg::in_item_t   item,
    output logic                rx_we,
    output logic [RX_AW-1:0]    rx_waddr,
    output logic [7:0]          rx_wdata,
    output logic                rx_re,
    output logic [RX_AW-1:0]    rx_raddr,
    output logic                tx_we,
    output logic [TX_AW-1:0]    tx_waddr,
    output logic [7:0]          tx_wdata,
    output logic                tx_re,
    output logic [TX_AW-1:0]    tx_raddr,
    output urf_pkg::urf_meta_t  meta
);

    localparam int RX_FW = $clog2(RX_FIFO_DEPTH + 1);
    localparam int TX_FW = $clog2(TX_FIFO_DEPTH + 1);
    localparam int RX_SW = RX_FW + 1;
    localparam int TX_SW = TX_FW + 1;

    // State registers
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_FW-1:0] rx_fill_reg, rx_fill_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_FW-1:0] tx_fill_reg, tx_fill_next;
    logic [3:0]       ier_reg, ier_next;
    logic [7:0]       lcr_reg, lcr_next;
    logic [4:0]       mcr_reg, mcr_next;
    logic [7:0]       dll_reg, dll_next;
    logic [7:0]       dlm_reg, dlm_next;
    logic [7:0]       scr_reg, scr_next;
    logic             fifo_on_reg, fifo_on_next;
    logic             overrun_reg, overrun_next;
    logic             busy_reg, busy_next;
    logic             thre_pend_reg, thre_pend_next;

    logic             dlab;
    logic [RX_FW-1:0] rx_cap;
    logic [TX_FW-1:0] tx_cap;
    logic [RX_SW-1:0] rx_tail_sum;
    logic [TX_SW-1:0] tx_tail_sum;
    logic [RX_AW-1:0] rx_tail;
    logic [TX_AW-1:0] tx_tail;
    logic [7:0]       isr_now;
    logic             fcr_en, fcr_clr_rx, fcr_clr_tx;

    // Pointer increment with wrap at the FIFO depth
    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        logic [RX_FW-1:0] t;
        t = RX_FW'(p) + RX_FW'(1);
        return (t == RX_FW'(RX_FIFO_DEPTH)) ? '0 : t[RX_AW-1:0];
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        logic [TX_FW-1:0] t;
        t = TX_FW'(p) + TX_FW'(1);
        return (t == TX_FW'(TX_FIFO_DEPTH)) ? '0 : t[TX_AW-1:0];
    endfunction

    assign dlab   = lcr_reg[urf_pkg::LCR_DLAB];
    assign rx_cap = fifo_on_reg ? RX_FW'(RX_FIFO_DEPTH) : RX_FW'(1);
    assign tx_cap = fifo_on_reg ? TX_FW'(TX_FIFO_DEPTH) : TX_FW'(1);

    // Tail (push) addresses: head + fill, wrapped once
    always_comb begin
        rx_tail_sum = RX_SW'(rx_head_reg) + RX_SW'(rx_fill_reg);
        if (rx_tail_sum >= RX_SW'(RX_FIFO_DEPTH)) begin
            rx_tail_sum = rx_tail_sum - RX_SW'(RX_FIFO_DEPTH);
        end
        tx_tail_sum = TX_SW'(tx_head_reg) + TX_SW'(tx_fill_reg);
        if (tx_tail_sum >= TX_SW'(TX_FIFO_DEPTH)) begin
            tx_tail_sum = tx_tail_sum - TX_SW'(TX_FIFO_DEPTH);
        end
    end

    assign rx_tail = rx_tail_sum[RX_AW-1:0];
    assign tx_tail = tx_tail_sum[TX_AW-1:0];

    assign isr_now = urf_pkg::isr_code(ier_reg, overrun_reg, rx_fill_reg != '0,
                                       thre_pend_reg);

    assign fcr_en     = item.write_data[urf_pkg::FCR_ENABLE];
    assign fcr_clr_rx = item.write_data[urf_pkg::FCR_CLR_RX] || (fcr_en != fifo_on_reg);
    assign fcr_clr_tx = item.write_data[urf_pkg::FCR_CLR_TX] || (fcr_en != fifo_on_reg);

    // Item decode and next-state logic
    always_comb begin
        rx_head_next   = rx_head_reg;
        rx_fill_next   = rx_fill_reg;
        tx_head_next   = tx_head_reg;
        tx_fill_next   = tx_fill_reg;
        ier_next       = ier_reg;
        lcr_next       = lcr_reg;
        mcr_next       = mcr_reg;
        dll_next       = dll_reg;
        dlm_next       = dlm_reg;
        scr_next       = scr_reg;
        fifo_on_next   = fifo_on_reg;
        overrun_next   = overrun_reg;
        busy_next      = busy_reg;
        thre_pend_next = thre_pend_reg;

        rx_we    = 1'b0;
        rx_waddr = rx_tail;
        rx_wdata = item.line_byte;
        rx_re    = 1'b0;
        rx_raddr = rx_head_reg;
        tx_we    = 1'b0;
        tx_waddr = tx_tail;
        tx_wdata = item.write_data;
        tx_re    = 1'b0;
        tx_raddr = tx_head_reg;
        meta     = '0;

        case (item.operation)
            urf_pkg::OP_BUS_READ: begin
                case (item.reg_offset)
                    urf_pkg::OFF_DATA: begin
                        if (dlab) begin
                            meta.rd_value = dll_reg;
                        end else if (rx_fill_reg != '0) begin
                            rx_re           = fire;
                            meta.rd_from_rx = 1'b1;
                            rx_head_next    = rx_inc(rx_head_reg);
                            rx_fill_next    = rx_fill_reg - RX_FW'(1);
                        end
                    end
                    urf_pkg::OFF_IER: begin
                        meta.rd_value = dlab ? dlm_reg : {4'b0, ier_reg};
                    end
                    urf_pkg::OFF_ISR_FCR: begin
                        if (isr_now == urf_pkg::ISR_THRE) begin
                            thre_pend_next = 1'b0;
                        end
                        meta.rd_value = fifo_on_reg ? (isr_now | urf_pkg::ISR_FIFO_ON)
                                                    : isr_now;
                    end
                    urf_pkg::OFF_LCR: meta.rd_value = lcr_reg;
                    urf_pkg::OFF_MCR: meta.rd_value = {3'b0, mcr_reg};
                    urf_pkg::OFF_LSR: begin
                        // DR, OE, THRE, TEMT
                        meta.rd_value = {1'b0,
                                         (tx_fill_reg == '0) && !busy_reg,
                                         tx_fill_reg == '0,
                                         3'b0,
                                         overrun_reg,
                                         rx_fill_reg != '0};
                        overrun_next  = 1'b0;
                    end
                    urf_pkg::OFF_SCRATCH: meta.rd_value = scr_reg;
                    default: meta.rd_value = '0;
                endcase
            end
            urf_pkg::OP_BUS_WRITE: begin
                case (item.reg_offset)
                    urf_pkg::OFF_DATA: begin
                        if (dlab) begin
                            dll_next = item.write_data;
                        end else begin
                            thre_pend_next = 1'b0;
                            if (tx_fill_reg < tx_cap) begin
                                tx_we        = fire;
                                tx_fill_next = tx_fill_reg + TX_FW'(1);
                            end
                        end
                    end
                    urf_pkg::OFF_IER: begin
                        if (dlab) begin
                            dlm_next = item.write_data;
                        end else begin
                            ier_next = item.write_data[3:0];
                            if (!ier_reg[urf_pkg::IER_TX] &&
                                item.write_data[urf_pkg::IER_TX] &&
                                (tx_fill_reg == '0)) begin
                                thre_pend_next = 1'b1;
                            end
                        end
                    end
                    urf_pkg::OFF_ISR_FCR: begin
                        fifo_on_next = fcr_en;
                        if (fcr_clr_rx) begin
                            rx_head_next = '0;
                            rx_fill_next = '0;
                        end
                        if (fcr_clr_tx) begin
                            tx_head_next = '0;
                            tx_fill_next = '0;
                        end
                    end
                    urf_pkg::OFF_LCR:     lcr_next = item.write_data;
                    urf_pkg::OFF_MCR:     mcr_next = item.write_data[4:0];
                    urf_pkg::OFF_SCRATCH: scr_next = item.write_data;
                    default: ;
                endcase
            end
            urf_pkg::OP_RX_BYTE: begin
                if (rx_fill_reg < rx_cap) begin
                    rx_we        = fire;
                    rx_fill_next = rx_fill_reg + RX_FW'(1);
                end else begin
                    overrun_next = 1'b1;
                end
            end
            default: begin
                busy_next = 1'b0;
            end
        endcase

        // Idle shifter takes the next byte from the transmit FIFO
        if (!busy_next && (tx_fill_next != '0)) begin
            tx_re            = fire;
            tx_raddr         = tx_head_next;
            meta.tx_valid    = 1'b1;
            // Byte pushed by this same item: RAM not yet written, forward it
            meta.tx_fwd      = tx_we && (tx_waddr == tx_head_next);
            meta.tx_fwd_data = item.write_data;
            tx_head_next     = tx_inc(tx_head_next);
            tx_fill_next     = tx_fill_next - TX_FW'(1);
            busy_next        = 1'b1;
            if (tx_fill_next == '0) begin
                thre_pend_next = 1'b1;
            end
        end

        meta.irq = urf_pkg::isr_code(ier_next, overrun_next, rx_fill_next != '0,
                                     thre_pend_next) != urf_pkg::ISR_NONE;
    end

    // State update on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg   <= '0;
            rx_fill_reg   <= '0;
            tx_head_reg   <= '0;
            tx_fill_reg   <= '0;
            ier_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            dll_reg       <= '0;
            dlm_reg       <= '0;
            scr_reg       <= '0;
            fifo_on_reg   <= 1'b0;
            overrun_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            thre_pend_reg <= 1'b0;
        end else if (fire) begin
            rx_head_reg   <= rx_head_next;
            rx_fill_reg   <= rx_fill_next;
            tx_head_reg   <= tx_head_next;
            tx_fill_reg   <= tx_fill_next;
            ier_reg       <= ier_next;
            lcr_reg       <= lcr_next;
            mcr_reg       <= mcr_next;
            dll_reg       <= dll_next;
            dlm_reg       <= dlm_next;
            scr_reg       <= scr_next;
            fifo_on_reg   <= fifo_on_next;
            overrun_reg   <= overrun_next;
            busy_reg      <= busy_next;
            thre_pend_reg <= thre_pend_next;
        end
    end

endmodule

### sim/uart_register_file_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_file_checker: result prediction and in-order comparison
// Keeps its own copy of the UART registers and FIFOs, works out the result
// of every accepted input item and compares each returned item against the
// oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module uart_register_file_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  urf_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  urf_pkg::out_item_t m_item,
    output int                 errors,
    output int                 outstanding
);
    import urf_pkg::*;

    localparam int unsigned RX_DEPTH = 16;
    localparam int unsigned TX_DEPTH = 16;

    // Line status bits
    localparam logic [7:0] LSR_DR   = 8'h01;
    localparam logic [7:0] LSR_OE   = 8'h02;
    localparam logic [7:0] LSR_THRE = 8'h20;
    localparam logic [7:0] LSR_TEMT = 8'h40;

    // Mirror of the register file
    logic [7:0]  rx_mem [RX_DEPTH];
    logic [7:0]  tx_mem [TX_DEPTH];
    int unsigned rx_rd, rx_count, tx_rd, tx_count;
    logic [3:0]  ier;
    logic [7:0]  lcr;
    logic [4:0]  mcr;
    logic [7:0]  dll, dlm, scr;
    logic        fifo_en, overrun, tx_busy, thre_pend;

    out_item_t   expected_results[$];
    int          mismatches = 0;

    assign errors = mismatches;

    function automatic void clear_uart();
        rx_rd     = 0;
        rx_count  = 0;
        tx_rd     = 0;
        tx_count  = 0;
        ier       = '0;
        lcr       = '0;
        mcr       = '0;
        dll       = '0;
        dlm       = '0;
        scr       = '0;
        fifo_en   = 1'b0;
        overrun   = 1'b0;
        tx_busy   = 1'b0;
        thre_pend = 1'b0;
    endfunction

    // Interrupt identification, highest priority first
    function automatic logic [7:0] irq_source();
        if (ier[IER_LS] && overrun) begin
            return ISR_LINE;
        end
        if (ier[IER_RX] && rx_count != 0) begin
            return ISR_RXDATA;
        end
        if (ier[IER_TX] && thre_pend) begin
            return ISR_THRE;
        end
        return ISR_NONE;
    endfunction

    function automatic logic [7:0] register_read(input logic [2:0] off);
        logic [7:0] v;
        logic       dlab;
        v    = 8'h00;
        dlab = lcr[LCR_DLAB];
        case (off)
            OFF_DATA: begin
                if (dlab) begin
                    v = dll;
                end else if (rx_count != 0) begin
                    v        = rx_mem[rx_rd];
                    rx_rd    = (rx_rd + 1) % RX_DEPTH;
                    rx_count = rx_count - 1;
                end
            end
            OFF_IER: begin
                v = dlab ? dlm : {4'h0, ier};
            end
            OFF_ISR_FCR: begin
                v = irq_source();
                if (v == ISR_THRE) begin
                    thre_pend = 1'b0;
                end
                if (fifo_en) begin
                    v = v | ISR_FIFO_ON;
                end
            end
            OFF_LCR: begin
                v = lcr;
            end
            OFF_MCR: begin
                v = {3'b000, mcr};
            end
            OFF_LSR: begin
                if (rx_count != 0) v = v | LSR_DR;
                if (overrun) v = v | LSR_OE;
                if (tx_count == 0) begin
                    v = v | LSR_THRE;
                    if (!tx_busy) v = v | LSR_TEMT;
                end
                overrun = 1'b0;
            end
            OFF_SCRATCH: begin
                v = scr;
            end
            default: begin
                v = 8'h00;
            end
        endcase
        return v;
    endfunction

    function automatic void register_write(input logic [2:0] off, input logic [7:0] d);
        logic       dlab;
        logic [3:0] old_ier;
        logic       en, clr_rx, clr_tx;
        dlab = lcr[LCR_DLAB];
        case (off)
            OFF_DATA: begin
                if (dlab) begin
                    dll = d;
                end else begin
                    thre_pend = 1'b0;
                    if (tx_count < (fifo_en ? TX_DEPTH : 1)) begin
                        tx_mem[(tx_rd + tx_count) % TX_DEPTH] = d;
                        tx_count = tx_count + 1;
                    end
                end
            end
            OFF_IER: begin
                if (dlab) begin
                    dlm = d;
                end else begin
                    old_ier = ier;
                    ier     = d[3:0];
                    if (!old_ier[IER_TX] && ier[IER_TX] && tx_count == 0) begin
                        thre_pend = 1'b1;
                    end
                end
            end
            OFF_ISR_FCR: begin
                en     = d[FCR_ENABLE];
                clr_rx = d[FCR_CLR_RX];
                clr_tx = d[FCR_CLR_TX];
                // toggling the enable flushes both sides
                if (en != fifo_en) begin
                    clr_rx = 1'b1;
                    clr_tx = 1'b1;
                end
                fifo_en = en;
                if (clr_rx) begin
                    rx_rd    = 0;
                    rx_count = 0;
                end
                if (clr_tx) begin
                    tx_rd    = 0;
                    tx_count = 0;
                end
            end
            OFF_LCR: begin
                lcr = d;
            end
            OFF_MCR: begin
                mcr = d[4:0];
            end
            OFF_SCRATCH: begin
                scr = d;
            end
            default: begin
            end
        endcase
    endfunction

    // Apply one item to the mirror and return the result it should give
    function automatic out_item_t predict_result(input in_item_t it);
        out_item_t  r;
        logic [7:0] code;
        r = '0;
        case (it.operation)
            OP_BUS_READ: begin
                r.read_data = register_read(it.reg_offset);
            end
            OP_BUS_WRITE: begin
                register_write(it.reg_offset, it.write_data);
            end
            OP_RX_BYTE: begin
                if (rx_count < (fifo_en ? RX_DEPTH : 1)) begin
                    rx_mem[(rx_rd + rx_count) % RX_DEPTH] = it.line_byte;
                    rx_count = rx_count + 1;
                end else begin
                    overrun = 1'b1;
                end
            end
            default: begin
                tx_busy = 1'b0;
            end
        endcase
        // idle shifter pulls the next byte
        if (!tx_busy && tx_count != 0) begin
            r.tx_byte  = tx_mem[tx_rd];
            r.tx_valid = 1'b1;
            tx_rd      = (tx_rd + 1) % TX_DEPTH;
            tx_count   = tx_count - 1;
            tx_busy    = 1'b1;
            if (tx_count == 0) begin
                thre_pend = 1'b1;
            end
        end
        code          = irq_source();
        r.irq_pending = ~code[0];
        return r;
    endfunction

    function automatic void compare_field(input string label, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            mismatches = mismatches + 1;
            $error("%s: expected %0h, got %0h", label, want, got);
        end
    endfunction

    // Predict on accept, compare on return
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_uart();
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_item));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    $error("result item with no outstanding prediction");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("read_data", want.read_data, m_item.read_data);
                    compare_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, m_item.tx_valid});
                    compare_field("tx_byte", want.tx_byte, m_item.tx_byte);
                    compare_field("irq_pending", {7'd0, want.irq_pending},
                                  {7'd0, m_item.irq_pending});
                end
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

### sim/uart_register_file_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_file_tb: testbench of the UART register file
// Drives a short directed sequence over the register map and the FIFO corner
// cases, then random episodes of mixed accesses and receive and transmit
// bursts, with random stalls on both channels. The checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module uart_register_file_tb;
    import urf_pkg::*;

    localparam int TOTAL_ITEMS  = 1900;
    localparam int TAIL_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT    = 400000;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    int         mismatch_total;
    int         results_due;
    int         cycle_count = 0;
    int         sent_count  = 0;
    int         gap_pct     = 0;
    bit         hurried     = 1'b0;

    always #2 aclk = ~aclk;

    uart_register_file uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    uart_register_file_checker results_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .errors      (mismatch_total),
        .outstanding (results_due)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[uart_register_file] ERROR");
            $finish;
        end
    end

    // Result side back-pressure in bursts
    initial begin
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            if (!hurried && $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end
    end

    // Random byte and random offset at field width
    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [2:0] rand_off();
        return 3'($urandom);
    endfunction

    // One item through the input handshake, with an optional gap first
    task automatic issue(input logic [1:0] op, input logic [2:0] off,
                         input logic [7:0] wd, input logic [7:0] lb);
        in_item_t it;
        it.operation  = op;
        it.reg_offset = off;
        it.write_data = wd;
        it.line_byte  = lb;
        if (!hurried && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    // Register offset for a random bus access, weighted toward the data port
    function automatic logic [2:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OFF_DATA;
        if (r < 47) return OFF_IER;
        if (r < 60) return OFF_ISR_FCR;
        if (r < 67) return OFF_LCR;
        if (r < 74) return OFF_MCR;
        if (r < 86) return OFF_LSR;
        if (r < 91) return OFF_MSR;
        return OFF_SCRATCH;
    endfunction

    // Write data suited to the offset: DLAB mostly off, FIFOs mostly on
    function automatic logic [7:0] pick_wdata(input logic [2:0] off);
        logic [7:0] d;
        d = rand_byte();
        if (off == OFF_LCR && $urandom_range(0, 4) != 0) d[LCR_DLAB] = 1'b0;
        if (off == OFF_ISR_FCR && $urandom_range(0, 3) != 0) d[FCR_ENABLE] = 1'b1;
        return d;
    endfunction

    task automatic random_episode();
        int         kind, n;
        logic [1:0] op;
        logic [2:0] off;
        kind    = $urandom_range(0, 9);
        n       = $urandom_range(1, 20);
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
        case (kind)
            5, 6: begin
                // receive burst of up to 20 bytes, which can pass the FIFO depth, then drain it
                issue(OP_BUS_WRITE, OFF_LCR, rand_byte() & 8'h7F, rand_byte());
                repeat (n) issue(OP_RX_BYTE, rand_off(), rand_byte(), rand_byte());
                repeat (n) begin
                    off = ($urandom_range(0, 9) < 8) ? OFF_DATA :
                          ($urandom_range(0, 1) == 0) ? OFF_LSR : OFF_ISR_FCR;
                    issue(OP_BUS_READ, off, rand_byte(), rand_byte());
                end
            end
            7, 8: begin
                // transmit burst, then shift-done events mixed with ISR reads to drain the FIFO
                issue(OP_BUS_WRITE, OFF_LCR, rand_byte() & 8'h7F, rand_byte());
                repeat (n) issue(OP_BUS_WRITE, OFF_DATA, rand_byte(), rand_byte());
                repeat (n + 1) begin
                    if ($urandom_range(0, 3) == 0) begin
                        issue(OP_BUS_READ, OFF_ISR_FCR, rand_byte(), rand_byte());
                    end else begin
                        issue(OP_SHIFT_DONE, rand_off(), rand_byte(), rand_byte());
                    end
                end
            end
            9: begin
                // divisor latch round trip and interrupt setup
                issue(OP_BUS_WRITE, OFF_LCR, rand_byte() | 8'h80, rand_byte());
                issue(OP_BUS_WRITE, OFF_DATA, rand_byte(), rand_byte());
                issue(OP_BUS_WRITE, OFF_IER, rand_byte(), rand_byte());
                issue(OP_BUS_READ, OFF_DATA, rand_byte(), rand_byte());
                issue(OP_BUS_READ, OFF_IER, rand_byte(), rand_byte());
                issue(OP_BUS_WRITE, OFF_LCR, rand_byte() & 8'h7F, rand_byte());
                issue(OP_BUS_WRITE, OFF_IER, rand_byte(), rand_byte());
                issue(OP_BUS_WRITE, OFF_ISR_FCR, pick_wdata(OFF_ISR_FCR), rand_byte());
                issue(OP_BUS_READ, OFF_ISR_FCR, rand_byte(), rand_byte());
            end
            default: begin
                // mixed traffic
                repeat (n) begin
                    op  = 2'($urandom_range(0, 3));
                    off = (op == OP_BUS_READ || op == OP_BUS_WRITE) ? pick_offset()
                                                                    : rand_off();
                    issue(op, off, pick_wdata(off), rand_byte());
                end
            end
        endcase
    endtask

    // Stimulus and verdict
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values and the THR-empty interrupt source
        issue(OP_BUS_READ,  OFF_LSR,     8'h00, 8'h00);
        issue(OP_BUS_WRITE, OFF_IER,     8'hFF, 8'h00);
        issue(OP_BUS_READ,  OFF_ISR_FCR, 8'h00, 8'h00);
        // divisor latch with DLAB set
        issue(OP_BUS_WRITE, OFF_LCR,     8'hFF, 8'h00);
        issue(OP_BUS_WRITE, OFF_DATA,    8'hFF, 8'h00);
        issue(OP_BUS_WRITE, OFF_IER,     8'h00, 8'hFF);
        issue(OP_BUS_READ,  OFF_DATA,    8'h00, 8'h00);
        issue(OP_BUS_READ,  OFF_IER,     8'h00, 8'h00);
        issue(OP_BUS_WRITE, OFF_LCR,     8'h00, 8'h00);
        // MCR masking, ignored writes, MSR
        issue(OP_BUS_WRITE, OFF_MCR,     8'hFF, 8'h00);
        issue(OP_BUS_READ,  OFF_MCR,     8'h00, 8'h00);
        issue(OP_BUS_WRITE, OFF_MSR,     8'hFF, 8'h00);
        issue(OP_BUS_READ,  OFF_MSR,     8'h00, 8'h00);
        // holding register overrun, line status priority, empty read
        issue(OP_RX_BYTE,   OFF_SCRATCH, 8'hFF, 8'hFF);
        issue(OP_RX_BYTE,   OFF_SCRATCH, 8'hFF, 8'h00);
        issue(OP_BUS_READ,  OFF_ISR_FCR, 8'h00, 8'h00);
        issue(OP_BUS_READ,  OFF_LSR,     8'h00, 8'h00);
        issue(OP_BUS_READ,  OFF_DATA,    8'h00, 8'h00);
        issue(OP_BUS_READ,  OFF_DATA,    8'h00, 8'h00);
        // transmit holding register full, shift done while idle
        issue(OP_BUS_WRITE, OFF_DATA,    8'h00, 8'h00);
        issue(OP_BUS_WRITE, OFF_DATA,    8'hFF, 8'h00);
        issue(OP_BUS_WRITE, OFF_DATA,    8'h5A, 8'h00);
        issue(OP_SHIFT_DONE, OFF_DATA,   8'h00, 8'h00);
        issue(OP_SHIFT_DONE, OFF_DATA,   8'h00, 8'h00);
        issue(OP_SHIFT_DONE, OFF_DATA,   8'h00, 8'h00);
        // FIFO enable on with both clears, then toggled off and on again
        issue(OP_BUS_WRITE, OFF_ISR_FCR, 8'h07, 8'h00);
        issue(OP_BUS_WRITE, OFF_ISR_FCR, 8'h00, 8'h00);
        issue(OP_BUS_WRITE, OFF_ISR_FCR, 8'h01, 8'h00);

        while (sent_count < TOTAL_ITEMS) begin
            if (sent_count >= TOTAL_ITEMS - TAIL_ITEMS) hurried = 1'b1;
            random_episode();
        end
        s_valid <= 1'b0;

        // wait for the last results, then watch for strays
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_total == 0 && results_due == 0) begin
            $display("[uart_register_file] OK");
        end else begin
            $display("[uart_register_file] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/urf_pkg.sv
sv/urf_ram.sv
sv/urf_ctrl.sv
sv/uart_register_file.sv
sim/uart_register_file_checker.sv
sim/uart_register_file_tb.sv
